// ===== rtl/core/bfs_pkg.sv =====
// Package for the biased factor SGD update block.
// Holds the channel payload types, command and target codes, engine states
// and the 32-bit saturation helper. Depends on nothing.
package bfs_pkg;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_TRAIN = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Parameter targets of write and read requests.
    localparam logic [2:0] TGT_UFAC  = 3'd0;
    localparam logic [2:0] TGT_IFAC  = 3'd1;
    localparam logic [2:0] TGT_UBIAS = 3'd2;
    localparam logic [2:0] TGT_IBIAS = 3'd3;
    localparam logic [2:0] TGT_GBIAS = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REG_WEIGHT = 4'd1;

    localparam logic [15:0] STEP_SIZE_RST  = 16'd655;
    localparam logic [15:0] REG_WEIGHT_RST = 16'd655;

    // Factor slot tag width, enough for the largest rank.
    localparam int SLOT_TAG_W = 6;

    // Width of the value handed to the saturation helper.
    localparam int SAT_W = 80;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         row_index;
        logic [9:0]         col_index;
        logic signed [31:0] rating;
        logic [15:0]        row_count;
        logic [15:0]        col_count;
        logic [2:0]         target;
        logic [3:0]         factor_slot;
        logic signed [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] prediction;
        logic signed [31:0] error;
        logic signed [31:0] read_value;
        logic               saturated;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          value;
    } cfg_t;

    // Register values the engine works with.
    typedef struct packed {
        logic [15:0] step_size;
        logic [15:0] reg_weight;
    } coef_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_SUM,
        ST_PRED,
        ST_ERR,
        ST_UPD,
        ST_FLUSH,
        ST_WR,
        ST_RD,
        ST_RDDATA,
        ST_DONE
    } eng_state_t;

    typedef enum logic [1:0] {
        DST_GBIAS,
        DST_UBIAS,
        DST_IBIAS,
        DST_UFAC
    } sgd_dest_t;

    typedef struct packed {
        sgd_dest_t              dest;
        logic [SLOT_TAG_W-1:0]  slot;
    } sgd_tag_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               clip;
    } sat_res_t;

    localparam logic signed [SAT_W-1:0] WORD_MAX = SAT_W'(32'sh7FFFFFFF);
    localparam logic signed [SAT_W-1:0] WORD_MIN = SAT_W'(32'sh80000000);

    // Clip a wide signed value to 32 bits and flag the clip.
    function automatic sat_res_t sat_word(input logic signed [SAT_W-1:0] x);
        sat_res_t r;
        if (x > WORD_MAX)
        begin
            r.value = 32'sh7FFFFFFF;
            r.clip  = 1'b1;
        end
        else if (x < WORD_MIN)
        begin
            r.value = 32'sh80000000;
            r.clip  = 1'b1;
        end
        else
        begin
            r.value = x[31:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/bfs_chan_if.sv =====
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; payload types come from bfs_pkg at instantiation.
interface bfs_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bfs_ram.sv =====
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
module bfs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bfs_div.sv =====
// Restoring 16-bit divider, one quotient bit per cycle.
// A divisor of zero divides by one. Depends on nothing.
module bfs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [15:0] quotient
);

    logic [4:0]  cnt_reg;
    logic [15:0] q_reg;
    logic [15:0] r_reg;
    logic [15:0] d_reg;
    logic [16:0] r_sh;
    logic        fits;

    assign r_sh = {r_reg, q_reg[15]};
    assign fits = r_sh >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 5'd16;
        end
        else if (cnt_reg != 5'd0)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= (divisor == 16'd0) ? 16'd1 : divisor;
        end
        else if (cnt_reg != 5'd0)
        begin
            q_reg <= {q_reg[14:0], fits};
            r_reg <= fits ? 16'(r_sh - {1'b0, d_reg}) : r_sh[15:0];
        end
    end

    assign busy     = cnt_reg != 5'd0;
    assign quotient = q_reg;

endmodule

// ===== rtl/core/bfs_sgd.sv =====
// Four-stage pipeline for one gradient step:
// p - ((eta * (grad + ((lam * p) >>> 16))) >>> 16), clipped to 32 bits.
// Uses bfs_pkg for the tag type and the saturation helper.
module bfs_sgd #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic signed [31:0] p,
    input  logic signed [31:0] err,
    input  logic signed [31:0] x,
    input  logic               use_x,
    input  logic [15:0]        lam,
    input  logic [15:0]        eta,
    input  bfs_pkg::sgd_tag_t  tag,
    output logic               out_valid,
    output logic signed [31:0] out_value,
    output logic               out_clip,
    output logic signed [31:0] out_x,
    output bfs_pkg::sgd_tag_t  out_tag,
    output logic               busy
);

    localparam int IW = 65 - FRAC_BITS;
    localparam int DW = IW + 17;
    localparam int SW = bfs_pkg::SAT_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [63:0]   m1_reg;
    logic signed [48:0]   m2_reg;
    logic signed [IW-1:0] inner_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [31:0]   p1_reg, p2_reg, p3_reg;
    logic signed [31:0]   x1_reg, x2_reg, x3_reg, x4_reg;
    logic                 use_x1_reg;
    bfs_pkg::sgd_tag_t    tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic signed [31:0]   value_reg;
    logic                 clip_reg;

    logic signed [IW-1:0] grad;
    logic signed [DW-1:0] diff;
    bfs_pkg::sat_res_t    sat;

    always_comb
    begin
        grad = use_x1_reg ? IW'(m1_reg >>> FRAC_BITS) : IW'(err);
        diff = DW'(p3_reg) - (d_reg >>> 16);
        sat  = bfs_pkg::sat_word(SW'(diff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // products
        m1_reg     <= 64'(err) * 64'(x);
        m2_reg     <= 49'(signed'({1'b0, lam})) * 49'(p);
        p1_reg     <= p;
        x1_reg     <= x;
        use_x1_reg <= use_x;
        tag1_reg   <= tag;
        // gradient plus decay
        inner_reg  <= grad + IW'(m2_reg >>> 16);
        p2_reg     <= p1_reg;
        x2_reg     <= x1_reg;
        tag2_reg   <= tag1_reg;
        // scale by step size
        d_reg      <= DW'(signed'({1'b0, eta})) * DW'(inner_reg);
        p3_reg     <= p2_reg;
        x3_reg     <= x2_reg;
        tag3_reg   <= tag2_reg;
        // subtract and clip
        value_reg  <= sat.value;
        clip_reg   <= sat.clip;
        x4_reg     <= x3_reg;
        tag4_reg   <= tag3_reg;
    end

    assign out_valid = v4_reg;
    assign out_value = value_reg;
    assign out_clip  = clip_reg;
    assign out_x     = x4_reg;
    assign out_tag   = tag4_reg;
    assign busy      = v1_reg | v2_reg | v3_reg | v4_reg;

endmodule

// ===== rtl/core/bfs_engine.sv =====
// Sequencer, parameter memories and datapath of the SGD update block.
// Uses bfs_pkg, bfs_ram, bfs_div and bfs_sgd.
module bfs_engine #(
    parameter int MAX_ROWS  = 1024,
    parameter int MAX_COLS  = 1024,
    parameter int RANK      = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  bfs_pkg::req_t     req,
    output logic              req_ready,
    input  bfs_pkg::coef_t    coef,
    output logic              res_valid,
    output bfs_pkg::rsp_t     res,
    input  logic              res_take
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CLW = $clog2(MAX_COLS);
    localparam int UD  = MAX_ROWS * RANK;
    localparam int VD  = MAX_COLS * RANK;
    localparam int UAW = $clog2(UD);
    localparam int VAW = $clog2(VD);
    localparam int CW  = $clog2(RANK + 3);
    localparam int TW  = bfs_pkg::SLOT_TAG_W;
    localparam int SW  = bfs_pkg::SAT_W;

    bfs_pkg::eng_state_t state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                accept;

    // item registers
    logic [1:0]          cmd_reg;
    logic [2:0]          target_reg;
    logic [3:0]          slot_reg;
    logic signed [31:0]  rating_reg;
    logic signed [31:0]  wval_reg;
    logic [RW-1:0]       i_reg;
    logic [CLW-1:0]      j_reg;
    logic [UAW-1:0]      ubase_reg;
    logic [VAW-1:0]      vbase_reg;
    logic                slot_ok;

    // results and state
    logic signed [31:0]  pred_reg, err_reg, rd_reg, g_reg;
    logic                flag_reg;
    logic signed [63:0]  prod_reg, acc_reg;
    logic                dv_reg, pv_reg, rv_reg;
    logic [TW-1:0]       rk_reg;

    logic [15:0]         i_wrap, j_wrap;

    // memory ports
    logic                u_we, v_we, bu_we, bv_we;
    logic [UAW-1:0]      u_waddr, u_raddr;
    logic [VAW-1:0]      v_waddr, v_raddr;
    logic [31:0]         u_wdata, v_wdata, bu_wdata, bv_wdata;
    logic signed [31:0]  u_rdata, v_rdata, bu_rdata, bv_rdata;

    // dividers
    logic                dr_busy, dc_busy;
    logic [15:0]         lam_r, lam_c;

    // update pipelines
    logic                su_in_valid, su_use_x;
    logic signed [31:0]  su_p, su_x;
    logic [15:0]         su_lam;
    bfs_pkg::sgd_tag_t   su_tag;
    logic                su_out_valid, su_clip, su_busy;
    logic signed [31:0]  su_value, su_x_out;
    bfs_pkg::sgd_tag_t   su_tag_out;
    logic                sv_in_valid, sv_out_valid, sv_clip, sv_busy;
    logic signed [31:0]  sv_value, sv_x_out;
    bfs_pkg::sgd_tag_t   sv_tag_out;

    bfs_pkg::sat_res_t   pred_sat, err_sat;

    assign accept  = req_valid && req_ready;
    assign slot_ok = 32'(slot_reg) < RANK;

    // Wrap the indexes into the table range.
    always_comb
    begin
        i_wrap = 16'(req.row_index);
        j_wrap = 16'(req.col_index);
        for (int b = 9; b >= 0; b--)
        begin
            if (32'(i_wrap) >= (MAX_ROWS << b))
            begin
                i_wrap = i_wrap - 16'(MAX_ROWS << b);
            end
            if (32'(j_wrap) >= (MAX_COLS << b))
            begin
                j_wrap = j_wrap - 16'(MAX_COLS << b);
            end
        end
    end

    // ---------------- state machine ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfs_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            bfs_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cnt_next  = '0;
                if (req_valid)
                begin
                    case (req.cmd)
                        bfs_pkg::CMD_TRAIN: state_next = bfs_pkg::ST_DOT;
                        bfs_pkg::CMD_WRITE: state_next = bfs_pkg::ST_WR;
                        bfs_pkg::CMD_READ:  state_next = bfs_pkg::ST_RD;
                        default:            state_next = bfs_pkg::ST_DONE;
                    endcase
                end
            end
            bfs_pkg::ST_DOT:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(RANK - 1))
                begin
                    state_next = bfs_pkg::ST_SUM;
                end
            end
            bfs_pkg::ST_SUM:
            begin
                if (!dv_reg && !pv_reg)
                begin
                    state_next = bfs_pkg::ST_PRED;
                end
            end
            bfs_pkg::ST_PRED:
            begin
                state_next = bfs_pkg::ST_ERR;
            end
            bfs_pkg::ST_ERR:
            begin
                cnt_next = '0;
                if (!dr_busy && !dc_busy)
                begin
                    state_next = bfs_pkg::ST_UPD;
                end
            end
            bfs_pkg::ST_UPD:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(RANK + 1))
                begin
                    state_next = bfs_pkg::ST_FLUSH;
                end
            end
            bfs_pkg::ST_FLUSH:
            begin
                if (!rv_reg && !su_busy && !sv_busy)
                begin
                    state_next = bfs_pkg::ST_DONE;
                end
            end
            bfs_pkg::ST_WR:
            begin
                state_next = bfs_pkg::ST_DONE;
            end
            bfs_pkg::ST_RD:
            begin
                state_next = bfs_pkg::ST_RDDATA;
            end
            bfs_pkg::ST_RDDATA:
            begin
                state_next = bfs_pkg::ST_DONE;
            end
            bfs_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = bfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfs_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- item capture and dot product ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= 1'b0;
            pv_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            dv_reg <= state_reg == bfs_pkg::ST_DOT;
            pv_reg <= dv_reg;
            rv_reg <= (state_reg == bfs_pkg::ST_UPD) && (cnt_reg >= CW'(2))
                      && (cnt_reg < CW'(RANK + 2));
        end
    end

    always_comb
    begin
        pred_sat = bfs_pkg::sat_word(SW'(acc_reg) + SW'(g_reg) + SW'(bu_rdata)
                                     + SW'(bv_rdata));
        err_sat  = bfs_pkg::sat_word(SW'(pred_reg) - SW'(rating_reg));
    end

    always_ff @(posedge clk)
    begin
        rk_reg   <= TW'(cnt_reg - CW'(2));
        prod_reg <= 64'(u_rdata) * 64'(v_rdata);
        if (accept)
        begin
            cmd_reg    <= req.cmd;
            target_reg <= req.target;
            slot_reg   <= req.factor_slot;
            rating_reg <= req.rating;
            wval_reg   <= req.write_value;
            i_reg      <= i_wrap[RW-1:0];
            j_reg      <= j_wrap[CLW-1:0];
            ubase_reg  <= UAW'(i_wrap) * UAW'(RANK);
            vbase_reg  <= VAW'(j_wrap) * VAW'(RANK);
            acc_reg    <= '0;
            pred_reg   <= '0;
            err_reg    <= '0;
            rd_reg     <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            if (pv_reg)
            begin
                acc_reg <= acc_reg + (prod_reg >>> FRAC_BITS);
            end
            if (state_reg == bfs_pkg::ST_PRED)
            begin
                pred_reg <= pred_sat.value;
            end
            if (state_reg == bfs_pkg::ST_ERR)
            begin
                err_reg <= err_sat.value;
            end
            if (state_reg == bfs_pkg::ST_RDDATA)
            begin
                if (target_reg == bfs_pkg::TGT_UFAC && slot_ok)
                    rd_reg <= u_rdata;
                else if (target_reg == bfs_pkg::TGT_IFAC && slot_ok)
                    rd_reg <= v_rdata;
                else if (target_reg == bfs_pkg::TGT_UBIAS)
                    rd_reg <= bu_rdata;
                else if (target_reg == bfs_pkg::TGT_IBIAS)
                    rd_reg <= bv_rdata;
                else if (target_reg == bfs_pkg::TGT_GBIAS)
                    rd_reg <= g_reg;
            end
            // collect clips from every stage of the step
            flag_reg <= flag_reg
                        | ((state_reg == bfs_pkg::ST_PRED) && pred_sat.clip)
                        | ((state_reg == bfs_pkg::ST_ERR) && err_sat.clip)
                        | (su_out_valid && su_clip)
                        | (sv_out_valid && sv_clip);
        end
    end

    // global bias lives in a register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg <= '0;
        end
        else if (state_reg == bfs_pkg::ST_WR && target_reg == bfs_pkg::TGT_GBIAS)
        begin
            g_reg <= wval_reg;
        end
        else if (su_out_valid && su_tag_out.dest == bfs_pkg::DST_GBIAS)
        begin
            g_reg <= su_value;
        end
    end

    // ---------------- memory ports ----------------
    always_comb
    begin
        case (state_reg)
            bfs_pkg::ST_DOT:
            begin
                u_raddr = ubase_reg + UAW'(cnt_reg);
                v_raddr = vbase_reg + VAW'(cnt_reg);
            end
            bfs_pkg::ST_UPD:
            begin
                u_raddr = ubase_reg + UAW'(cnt_reg - CW'(2));
                v_raddr = vbase_reg + VAW'(cnt_reg - CW'(2));
            end
            default:
            begin
                u_raddr = ubase_reg + UAW'(slot_reg);
                v_raddr = vbase_reg + VAW'(slot_reg);
            end
        endcase

        if (state_reg == bfs_pkg::ST_WR)
        begin
            u_we     = target_reg == bfs_pkg::TGT_UFAC && slot_ok;
            u_waddr  = ubase_reg + UAW'(slot_reg);
            u_wdata  = wval_reg;
            v_we     = target_reg == bfs_pkg::TGT_IFAC && slot_ok;
            v_waddr  = vbase_reg + VAW'(slot_reg);
            v_wdata  = wval_reg;
            bu_we    = target_reg == bfs_pkg::TGT_UBIAS;
            bu_wdata = wval_reg;
            bv_we    = target_reg == bfs_pkg::TGT_IBIAS;
            bv_wdata = wval_reg;
        end
        else
        begin
            u_we     = su_out_valid && su_tag_out.dest == bfs_pkg::DST_UFAC;
            u_waddr  = ubase_reg + UAW'(su_tag_out.slot);
            u_wdata  = su_value;
            v_we     = sv_out_valid;
            v_waddr  = vbase_reg + VAW'(sv_tag_out.slot);
            v_wdata  = sv_value;
            bu_we    = su_out_valid && su_tag_out.dest == bfs_pkg::DST_UBIAS;
            bu_wdata = su_value;
            bv_we    = su_out_valid && su_tag_out.dest == bfs_pkg::DST_IBIAS;
            bv_wdata = su_value;
        end
    end

    bfs_ram #(.DEPTH(UD), .WIDTH(32)) u_ufac_ram (
        .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .raddr(u_raddr), .rdata(u_rdata)
    );

    bfs_ram #(.DEPTH(VD), .WIDTH(32)) u_ifac_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    bfs_ram #(.DEPTH(MAX_ROWS), .WIDTH(32)) u_ubias_ram (
        .clk(clk), .we(bu_we), .waddr(i_reg), .wdata(bu_wdata),
        .raddr(i_reg), .rdata(bu_rdata)
    );

    bfs_ram #(.DEPTH(MAX_COLS), .WIDTH(32)) u_ibias_ram (
        .clk(clk), .we(bv_we), .waddr(j_reg), .wdata(bv_wdata),
        .raddr(j_reg), .rdata(bv_rdata)
    );

    // ---------------- scaled regularization ----------------
    bfs_div u_div_row (
        .clk(clk), .rst_n(rst_n),
        .start(accept && req.cmd == bfs_pkg::CMD_TRAIN),
        .dividend(coef.reg_weight), .divisor(req.row_count),
        .busy(dr_busy), .quotient(lam_r)
    );

    bfs_div u_div_col (
        .clk(clk), .rst_n(rst_n),
        .start(accept && req.cmd == bfs_pkg::CMD_TRAIN),
        .dividend(coef.reg_weight), .divisor(req.col_count),
        .busy(dc_busy), .quotient(lam_c)
    );

    // ---------------- update pipelines ----------------
    // Biases go first, one per cycle, then user factor k as its read returns.
    always_comb
    begin
        su_in_valid = rv_reg || (state_reg == bfs_pkg::ST_UPD && cnt_reg < CW'(3));
        su_use_x    = 1'b0;
        su_x        = '0;
        su_tag.slot = rk_reg;
        if (rv_reg)
        begin
            su_p       = u_rdata;
            su_x       = v_rdata;
            su_use_x   = 1'b1;
            su_lam     = lam_r;
            su_tag.dest = bfs_pkg::DST_UFAC;
        end
        else if (cnt_reg == CW'(0))
        begin
            su_p       = g_reg;
            su_lam     = coef.reg_weight;
            su_tag.dest = bfs_pkg::DST_GBIAS;
        end
        else if (cnt_reg == CW'(1))
        begin
            su_p       = bu_rdata;
            su_lam     = lam_r;
            su_tag.dest = bfs_pkg::DST_UBIAS;
        end
        else
        begin
            su_p       = bv_rdata;
            su_lam     = lam_c;
            su_tag.dest = bfs_pkg::DST_IBIAS;
        end
    end

    bfs_sgd #(.FRAC_BITS(FRAC_BITS)) u_sgd_user (
        .clk(clk), .rst_n(rst_n), .in_valid(su_in_valid),
        .p(su_p), .err(err_reg), .x(su_x), .use_x(su_use_x),
        .lam(su_lam), .eta(coef.step_size), .tag(su_tag),
        .out_valid(su_out_valid), .out_value(su_value), .out_clip(su_clip),
        .out_x(su_x_out), .out_tag(su_tag_out), .busy(su_busy)
    );

    // Item factor k follows with the freshly updated user factor k.
    assign sv_in_valid = su_out_valid && su_tag_out.dest == bfs_pkg::DST_UFAC;

    bfs_sgd #(.FRAC_BITS(FRAC_BITS)) u_sgd_item (
        .clk(clk), .rst_n(rst_n), .in_valid(sv_in_valid),
        .p(su_x_out), .err(err_reg), .x(su_value), .use_x(1'b1),
        .lam(lam_c), .eta(coef.step_size), .tag(su_tag_out),
        .out_valid(sv_out_valid), .out_value(sv_value), .out_clip(sv_clip),
        .out_x(sv_x_out), .out_tag(sv_tag_out), .busy(sv_busy)
    );

    assign res.prediction = pred_reg;
    assign res.error      = err_reg;
    assign res.read_value = rd_reg;
    assign res.saturated  = flag_reg;

endmodule

// ===== rtl/core/biased_factor_sgd_update_top.sv =====
// Top level of the biased factor SGD update block.
// Depends on bfs_pkg, bfs_chan_if and bfs_engine.
//
// Usage:
//   req  - request channel (valid/ready, bfs_pkg::req_t). cmd selects train,
//          write parameter or read parameter; every request gives one response.
//   rsp  - response channel (valid/ready, bfs_pkg::rsp_t): prediction and
//          error for train requests, read_value for reads, saturated flag.
//   cfg  - register write channel (index, value), always ready. Index 0 is
//          step_size, index 1 is reg_weight; other indexes are ignored.
//          Write only while no request is in flight.
// Sequencing: one request at a time. A train request makes a dot-product pass
//   over the factor rows, then a pass through the two chained update pipelines;
//   the count dividers can hold it between the two. Writes, reads and unknown
//   commands skip both passes.
// Reset clears the sequencer, the response register, the global bias and the
//   registers to 655. Factor and bias memories hold nothing until written.
// A stalled receiver holds the response in the output register; the block
//   still accepts and works the next request, which then waits to hand over.
module biased_factor_sgd_update_top #(
    parameter int MAX_ROWS  = 1024,
    parameter int MAX_COLS  = 1024,
    parameter int RANK      = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    bfs_chan_if.sink   req,
    bfs_chan_if.source rsp,
    bfs_chan_if.sink   cfg
);

    logic [15:0]    step_size_reg;
    logic [15:0]    reg_weight_reg;
    bfs_pkg::coef_t coef;

    logic           eng_ready;
    logic           eng_valid;
    bfs_pkg::rsp_t  eng_res;
    logic           eng_take;

    logic           out_valid_reg;
    bfs_pkg::rsp_t  out_data_reg;

    // Register writes are always taken; drop unknown indexes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= bfs_pkg::STEP_SIZE_RST;
            reg_weight_reg <= bfs_pkg::REG_WEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.data.index == bfs_pkg::REG_STEP_SIZE)
            begin
                step_size_reg <= cfg.data.value;
            end
            if (cfg.data.index == bfs_pkg::REG_REG_WEIGHT)
            begin
                reg_weight_reg <= cfg.data.value;
            end
        end
    end

    assign coef.step_size  = step_size_reg;
    assign coef.reg_weight = reg_weight_reg;

    // The engine takes a request whenever it is idle.
    assign req.ready = eng_ready;

    bfs_engine #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS),
        .RANK(RANK),
        .FRAC_BITS(FRAC_BITS)
    ) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req.valid),
        .req(req.data),
        .req_ready(eng_ready),
        .coef(coef),
        .res_valid(eng_valid),
        .res(eng_res),
        .res_take(eng_take)
    );

    // Advance a finished result into the output register once it is free
    // or being emptied in the same cycle; otherwise hold it in the engine.
    assign eng_take = eng_valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_take)
        begin
            out_data_reg <= eng_res;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

// ===== rtl/core/bfs_checker.sv =====
// Port-level checks for biased_factor_sgd_update_top, attached by bind.
// Depends on bfs_pkg for the response type.
module bfs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input bfs_pkg::rsp_t rsp_data
);

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response dropped or changed while stalled");

    // One request at a time: no request taken right after another.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !(req_valid && req_ready))
        else $error("two requests taken back to back");

    // A response never shows up in the cycle right after a request is taken.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("response appeared too early");

    // Reset empties the response register.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

endmodule

bind biased_factor_sgd_update_top bfs_checker u_bfs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_data(rsp.data)
);
